[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the overlay blender RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define PRAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked through reset as well
`define PRAB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/prab_pkg.sv]
// ---------------------------------------------------------------------------
// prab_pkg
// Widths, register indexes and constants for the pulsing overlay blender.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prab_pkg;

  localparam int POS_W   = 12;
  localparam int PIX_W   = 32;
  localparam int DEPTH_W = 6;
  localparam int CHAN_W  = 8;
  localparam int ALPHA_W = 7;
  localparam int PHASE_W = 6;
  localparam int SUM_W   = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 12;

  typedef enum logic [IDX_W-1:0] {
    REG_PIXEL_DEPTH = 3'd0,
    REG_RECT_WIDTH  = 3'd1,
    REG_RECT_HEIGHT = 3'd2,
    REG_COLOR_RED   = 3'd3,
    REG_COLOR_GREEN = 3'd4,
    REG_COLOR_BLUE  = 3'd5
  } reg_index_t;

  localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;
  localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;

  localparam logic [PHASE_W-1:0] PHASE_MID  = 6'd30;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 6'd59;
  localparam logic [ALPHA_W-1:0] ALPHA_BASE = 7'd80;
  localparam logic [CHAN_W-1:0]  FULL_SCALE = 8'd255;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 6'd32;
  localparam logic [POS_W-1:0]   WIDTH_RESET  = 12'd400;
  localparam logic [POS_W-1:0]   HEIGHT_RESET = 12'd200;
  localparam logic [CHAN_W-1:0]  RED_RESET    = 8'd0;
  localparam logic [CHAN_W-1:0]  GREEN_RESET  = 8'd255;
  localparam logic [CHAN_W-1:0]  BLUE_RESET   = 8'd0;

endpackage

`default_nettype wire

[rtl/prab_in_if.sv]
// ---------------------------------------------------------------------------
// prab_in_if
// Pixel request channel: coordinates, original pixel and frame end mark.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prab_in_if;
  import prab_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [PIX_W-1:0]   pixel_in;
  logic               frame_end;

  modport source (output valid, output pos_x, output pos_y, output pixel_in,
                  output frame_end, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pixel_in,
                  input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/prab_out_if.sv]
// ---------------------------------------------------------------------------
// prab_out_if
// Result channel: output pixel and status flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prab_out_if;
  import prab_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic               blended;
  logic               depth_error;
  logic               frame_done;

  modport source (output valid, output pixel_out, output blended,
                  output depth_error, output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input blended,
                  input depth_error, input frame_done, output ready);
endinterface

`default_nettype wire

[rtl/prab_cfg_if.sv]
// ---------------------------------------------------------------------------
// prab_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prab_cfg_if;
  import prab_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/pulsing_rect_alpha_blend.sv]
// ---------------------------------------------------------------------------
// pulsing_rect_alpha_blend
// Blends pixels inside a top-left rectangle with an overlay color whose
// opacity pulses per frame; 32 bpp and RGB565 16 bpp pixel formats.
// Stages from pixel request to result: decode, multiply, divide.
// Throughput: one pixel per cycle; a stalled result stalls all three stages.
// Reset: registers return to 32 bpp, 400x200, green; pulse phase to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pulsing_rect_alpha_blend (
  input  wire logic  clk,
  input  wire logic  rst,
  prab_in_if.sink    pixel,
  prab_out_if.source result,
  prab_cfg_if.sink   regs
);
  import prab_pkg::*;

  // register file
  logic [DEPTH_W-1:0] pixel_depth;
  logic [POS_W-1:0]   rect_width;
  logic [POS_W-1:0]   rect_height;
  logic [CHAN_W-1:0]  color_red;
  logic [CHAN_W-1:0]  color_green;
  logic [CHAN_W-1:0]  color_blue;

  assign regs.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth <= DEPTH_RESET;
      rect_width  <= WIDTH_RESET;
      rect_height <= HEIGHT_RESET;
      color_red   <= RED_RESET;
      color_green <= GREEN_RESET;
      color_blue  <= BLUE_RESET;
    end else if (regs.valid) begin
      case (reg_index_t'(regs.index))
        REG_PIXEL_DEPTH: pixel_depth <= regs.data[DEPTH_W-1:0];
        REG_RECT_WIDTH:  rect_width  <= regs.data[POS_W-1:0];
        REG_RECT_HEIGHT: rect_height <= regs.data[POS_W-1:0];
        REG_COLOR_RED:   color_red   <= regs.data[CHAN_W-1:0];
        REG_COLOR_GREEN: color_green <= regs.data[CHAN_W-1:0];
        REG_COLOR_BLUE:  color_blue  <= regs.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic in_acc;

  assign en          = !result.valid || result.ready;
  assign pixel.ready = en;
  assign in_acc      = pixel.valid && en;

  // pulse phase
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] phase_dist;
  logic [ALPHA_W-1:0] alpha_next;

  always_comb begin
    phase_next = (phase == PHASE_LAST) ? '0 : phase + 6'd1;
    phase_dist = (phase >= PHASE_MID) ? phase - PHASE_MID : PHASE_MID - phase;
    alpha_next = ALPHA_BASE + {1'b0, phase_dist};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_acc && pixel.frame_end) begin
      phase <= phase_next;
    end
  end

  // stage 1: decode
  logic               is32;
  logic               is16;
  logic               in_rect;
  logic [CHAN_W-1:0]  r_next;
  logic [CHAN_W-1:0]  g_next;
  logic [CHAN_W-1:0]  b_next;

  always_comb begin
    is32    = pixel_depth == DEPTH_32;
    is16    = pixel_depth == DEPTH_16;
    in_rect = (pixel.pos_x < rect_width) && (pixel.pos_y < rect_height);
    if (is16) begin
      r_next = {pixel.pixel_in[15:11], pixel.pixel_in[15:13]};
      g_next = {pixel.pixel_in[10:5], pixel.pixel_in[10:9]};
      b_next = {pixel.pixel_in[4:0], pixel.pixel_in[4:2]};
    end else begin
      r_next = pixel.pixel_in[23:16];
      g_next = pixel.pixel_in[15:8];
      b_next = pixel.pixel_in[7:0];
    end
  end

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [ALPHA_W-1:0] s1_alpha;
  logic [CHAN_W-1:0]  s1_r;
  logic [CHAN_W-1:0]  s1_g;
  logic [CHAN_W-1:0]  s1_b;
  logic               s1_is16;
  logic               s1_blend;
  logic               s1_err;
  logic               s1_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix   <= pixel.pixel_in;
      s1_alpha <= alpha_next;
      s1_r     <= r_next;
      s1_g     <= g_next;
      s1_b     <= b_next;
      s1_is16  <= is16;
      s1_blend <= in_rect && (is32 || is16);
      s1_err   <= !(is32 || is16);
      s1_fend  <= pixel.frame_end;
    end
  end

  // stage 2: weighted sums inside the channel units
  logic [CHAN_W-1:0] r_q;
  logic [CHAN_W-1:0] g_q;
  logic [CHAN_W-1:0] b_q;

  prab_mix u_mix_r (
    .clk   (clk),
    .en    (en),
    .alpha (s1_alpha),
    .ov    (color_red),
    .orig  (s1_r),
    .q     (r_q)
  );

  prab_mix u_mix_g (
    .clk   (clk),
    .en    (en),
    .alpha (s1_alpha),
    .ov    (color_green),
    .orig  (s1_g),
    .q     (g_q)
  );

  prab_mix u_mix_b (
    .clk   (clk),
    .en    (en),
    .alpha (s1_alpha),
    .ov    (color_blue),
    .orig  (s1_b),
    .q     (b_q)
  );

  logic             s2_valid;
  logic [PIX_W-1:0] s2_pix;
  logic             s2_is16;
  logic             s2_blend;
  logic             s2_err;
  logic             s2_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pix   <= s1_pix;
      s2_is16  <= s1_is16;
      s2_blend <= s1_blend;
      s2_err   <= s1_err;
      s2_fend  <= s1_fend;
    end
  end

  // stage 3: divide and repack into the output register
  logic [PIX_W-1:0] pix_next;

  always_comb begin
    if (!s2_blend) begin
      pix_next = s2_pix;
    end else if (s2_is16) begin
      pix_next = {s2_pix[31:16], r_q[7:3], g_q[7:2], b_q[7:3]};
    end else begin
      pix_next = {s2_pix[31:24], r_q, g_q, b_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.pixel_out   <= pix_next;
      result.blended     <= s2_blend;
      result.depth_error <= s2_err;
      result.frame_done  <= s2_fend;
    end
  end

  `PRAB_ASSERT(a_phase_adv, (in_acc && pixel.frame_end) |=> (phase == (($past(phase) == PHASE_LAST) ? 6'd0 : $past(phase) + 6'd1)), "phase did not advance on frame end")
  `PRAB_ASSERT(a_phase_hold, !(in_acc && pixel.frame_end) |=> $stable(phase), "phase moved without a frame end")
  `PRAB_ASSERT(a_flags, result.valid |-> !(result.blended && result.depth_error), "blended pixel flagged with a depth error")
  `PRAB_ASSERT_ALWAYS(a_stall, (result.valid && !result.ready) |-> !pixel.ready, "pixel request taken while result stalled")

endmodule

`default_nettype wire

[rtl/prab_mix.sv]
// ---------------------------------------------------------------------------
// prab_mix
// One color channel: weighted sum registered, then divided by 255.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prab_mix (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [prab_pkg::ALPHA_W-1:0]  alpha,
  input  wire logic [prab_pkg::CHAN_W-1:0]   ov,
  input  wire logic [prab_pkg::CHAN_W-1:0]   orig,
  output      logic [prab_pkg::CHAN_W-1:0]   q
);
  import prab_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [CHAN_W-1:0] inv;
  logic [SUM_W-1:0]  rnd;

  always_comb begin
    inv      = FULL_SCALE - {1'b0, alpha};
    sum_next = ({{(SUM_W-ALPHA_W){1'b0}}, alpha} * {{(SUM_W-CHAN_W){1'b0}}, ov})
             + ({{(SUM_W-CHAN_W){1'b0}}, inv} * {{(SUM_W-CHAN_W){1'b0}}, orig});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

  // exact floor(sum / 255) for sum up to 65025 (255 * 255)
  always_comb begin
    rnd = sum + 16'd1 + {{(SUM_W-CHAN_W){1'b0}}, sum[SUM_W-1:CHAN_W]};
    q   = rnd[SUM_W-1:CHAN_W];
  end

endmodule

`default_nettype wire
